/* src/fbpa_pkg.sv */
// Shared definitions for the fixed block pool allocator.
// Field widths, status codes, register indexes and parameter defaults.
// No dependencies.
package fbpa_pkg;

    localparam int MAX_BLOCKS_DEF   = 64;
    localparam int HEADER_BYTES_DEF = 8;
    localparam int ALIGN_MASK_DEF   = 7;

    localparam int MODE_W     = 1;
    localparam int IN_INDEX_W = 6;
    localparam int STATUS_W   = 2;
    localparam int GRANT_W    = 6;
    localparam int OFFSET_W   = 22;
    localparam int COUNT_W    = 7;
    localparam int SIZE_W     = 16;
    localparam int STRIDE_W   = 17;

    // The block count register cannot hold more than this many blocks.
    localparam int COUNT_LIMIT = (1 << COUNT_W) - 1;

    localparam int BLOCK_COUNT_RESET = 64;
    localparam int PAYLOAD_LEN_RESET = 64;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PAYLOAD_LEN = 2'd1;

    localparam logic [MODE_W-1:0] MODE_ALLOC = 1'b0;
    localparam logic [MODE_W-1:0] MODE_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_ALLOC = 2'd2,
        ST_RANGE     = 2'd3
    } t_status;

endpackage

/* src/fbpa_find_free.sv */
// Find-first-free encoder for the fixed block pool allocator.
// Takes a mask of free, eligible blocks and returns the lowest one.
// No package dependencies.
module fbpa_find_free #(
    parameter int DEPTH = 64,
    parameter int IDX_W = 6
) (
    input  logic [DEPTH-1:0] i_free,
    output logic             o_found,
    output logic [IDX_W-1:0] o_index
);

    logic [DEPTH-1:0] lowest;

    // Isolate the lowest set bit, then encode it with an OR per index bit.
    assign lowest  = i_free & (~i_free + DEPTH'(1));
    assign o_found = |i_free;

    always_comb begin
        o_index = '0;
        for (int i = 0; i < DEPTH; i++) begin
            o_index = o_index | ({IDX_W{lowest[i]}} & IDX_W'(i));
        end
    end

endmodule

/* src/fixed_block_pool_allocator_unit.sv */
// Top level of the fixed block pool allocator.
// Uses fbpa_pkg for widths and codes and fbpa_find_free for the search.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries a request item: i_mode
//   selects allocate or free, i_block_index names the block to free.
//   Output channel (o_out_valid / i_out_ready) returns one result item per
//   request: status, granted index, payload byte offset and free count.
//   Configuration channel (i_cfg_valid / o_cfg_ready) writes the block count
//   (index 0, clears the pool) or the payload length (index 1). It is always
//   ready; the user writes only with no request in flight (not enforced).
// Timing:
//   A request is registered on acceptance and its result is registered once
//   the output can advance. One item per cycle is sustained while the receiver
//   does not stall; the used-map search and the index-times-stride multiply
//   sit between the input register and the result register.
// Reset and stall:
//   Synchronous active-low reset frees every block, sets the block count and
//   payload length to 64 and empties both registers. While the receiver
//   stalls, the result holds and one further request can wait in the input
//   register.
module fixed_block_pool_allocator_unit #(
    parameter int MAX_BLOCKS   = fbpa_pkg::MAX_BLOCKS_DEF,
    parameter int HEADER_BYTES = fbpa_pkg::HEADER_BYTES_DEF,
    parameter int ALIGN_MASK   = fbpa_pkg::ALIGN_MASK_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,

    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [fbpa_pkg::MODE_W-1:0]        i_mode,
    input  logic [fbpa_pkg::IN_INDEX_W-1:0]    i_block_index,

    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [fbpa_pkg::STATUS_W-1:0]      o_status,
    output logic [fbpa_pkg::GRANT_W-1:0]       o_granted_index,
    output logic [fbpa_pkg::OFFSET_W-1:0]      o_payload_offset,
    output logic [fbpa_pkg::COUNT_W-1:0]       o_free_count,

    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [fbpa_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int CW = fbpa_pkg::COUNT_W;
    localparam int SW = fbpa_pkg::STRIDE_W;
    localparam int OW = fbpa_pkg::OFFSET_W;
    // Blocks beyond what the count register can name are never reachable.
    localparam int DEPTH = (MAX_BLOCKS < fbpa_pkg::COUNT_LIMIT) ?
                           MAX_BLOCKS : fbpa_pkg::COUNT_LIMIT;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PROD_RAW = IDX_W + SW + 1;
    localparam int PROD_W = (PROD_RAW > OW) ? PROD_RAW : OW;
    localparam int COUNT_RESET = (fbpa_pkg::BLOCK_COUNT_RESET < MAX_BLOCKS) ?
                                 fbpa_pkg::BLOCK_COUNT_RESET : MAX_BLOCKS;
    localparam int STRIDE_RESET = (fbpa_pkg::PAYLOAD_LEN_RESET + HEADER_BYTES +
                                   ALIGN_MASK) & ~ALIGN_MASK;

    logic                                  r_in_valid;
    logic [fbpa_pkg::MODE_W-1:0]           r_in_mode;
    logic [fbpa_pkg::IN_INDEX_W-1:0]       r_in_index;

    logic                                  r_out_valid;
    fbpa_pkg::t_status                     r_status;
    logic [fbpa_pkg::GRANT_W-1:0]          r_granted;
    logic [OW-1:0]                         r_offset;
    logic [CW-1:0]                         r_free;

    logic [DEPTH-1:0]                      r_map;
    logic [CW-1:0]                         r_used_count;
    logic [CW-1:0]                         r_block_count;
    logic [SW-1:0]                         r_stride;

    fbpa_pkg::t_status                     n_status;
    logic [fbpa_pkg::GRANT_W-1:0]          n_granted;
    logic [OW-1:0]                         n_offset;
    logic [CW-1:0]                         n_free;
    logic [DEPTH-1:0]                      n_map;
    logic [CW-1:0]                         n_used_count;
    logic [CW-1:0]                         n_block_count;
    logic [SW-1:0]                         n_stride;

    logic                                  advance;
    logic                                  in_fire;
    logic                                  work;
    logic                                  cfg_fire;
    logic [DEPTH-1:0]                      free_mask;
    logic                                  found;
    logic [IDX_W-1:0]                      found_index;
    logic [IDX_W-1:0]                      map_idx;
    logic [PROD_W-1:0]                     product;
    logic [fbpa_pkg::SIZE_W-1:0]           size_val;

    assign advance     = !r_out_valid || i_out_ready;
    assign o_in_ready  = !r_in_valid || advance;
    assign in_fire     = i_in_valid && o_in_ready;
    assign work        = r_in_valid && advance;
    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            free_mask[i] = !r_map[i] && (32'(i) < 32'(r_block_count));
        end
    end

    fbpa_find_free #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_find_free (
        .i_free  (free_mask),
        .o_found (found),
        .o_index (found_index)
    );

    assign map_idx = IDX_W'(r_in_index);
    assign product = PROD_W'(found_index) * PROD_W'(r_stride) + PROD_W'(HEADER_BYTES);

    // Request processing: one item per cycle, unless the output stalls, against the current used map.
    always_comb begin
        n_status     = fbpa_pkg::ST_OK;
        n_granted    = '0;
        n_offset     = '0;
        n_map        = r_map;
        n_used_count = r_used_count;
        if (r_in_mode == fbpa_pkg::MODE_ALLOC) begin
            if (found) begin
                n_map[found_index] = 1'b1;
                n_used_count       = r_used_count + CW'(1);
                n_granted          = fbpa_pkg::GRANT_W'(found_index);
                n_offset           = product[OW-1:0];
            end else begin
                n_status = fbpa_pkg::ST_EMPTY;
            end
        end else begin
            if ((32'(r_in_index) >= 32'(r_block_count)) ||
                (32'(r_in_index) >= 32'(DEPTH))) begin
                n_status = fbpa_pkg::ST_RANGE;
            end else if (!r_map[map_idx]) begin
                n_status = fbpa_pkg::ST_NOT_ALLOC;
            end else begin
                n_map[map_idx] = 1'b0;
                if (r_used_count != '0) begin
                    n_used_count = r_used_count - CW'(1);
                end
            end
        end
        n_free = r_block_count - n_used_count;
    end

    // Configuration values with zero and overrange corrections.
    always_comb begin
        n_block_count = i_cfg_data[CW-1:0];
        if (n_block_count == '0) begin
            n_block_count = CW'(1);
        end
        if (32'(n_block_count) > 32'(MAX_BLOCKS)) begin
            n_block_count = CW'(MAX_BLOCKS);
        end
        size_val = i_cfg_data[fbpa_pkg::SIZE_W-1:0];
        if (size_val == '0) begin
            size_val = fbpa_pkg::SIZE_W'(1);
        end
        n_stride = (SW'(size_val) + SW'(HEADER_BYTES) + SW'(ALIGN_MASK)) & ~SW'(ALIGN_MASK);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_map         <= '0;
            r_used_count  <= '0;
            r_block_count <= CW'(COUNT_RESET);
            r_stride      <= SW'(STRIDE_RESET);
        end else begin
            if (in_fire) begin
                r_in_valid <= 1'b1;
                r_in_mode  <= i_mode;
                r_in_index <= i_block_index;
            end else if (work) begin
                r_in_valid <= 1'b0;
            end

            if (work) begin
                r_out_valid  <= 1'b1;
                r_status     <= n_status;
                r_granted    <= n_granted;
                r_offset     <= n_offset;
                r_free       <= n_free;
                r_map        <= n_map;
                r_used_count <= n_used_count;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            // The user must write only while the block is idle; the block does not enforce this.
            if (cfg_fire) begin
                if (i_cfg_index == fbpa_pkg::REG_BLOCK_COUNT) begin
                    r_block_count <= n_block_count;
                    r_map         <= '0;
                    r_used_count  <= '0;
                end else if (i_cfg_index == fbpa_pkg::REG_PAYLOAD_LEN) begin
                    r_stride <= n_stride;
                end
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_granted_index  = r_granted;
    assign o_payload_offset = r_offset;
    assign o_free_count     = r_free;

    // The used count can never pass the number of blocks in the pool.
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used_count <= r_block_count)
        else $error("used count exceeds block count");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_block_count != '0) && (32'(r_block_count) <= 32'(MAX_BLOCKS)))
        else $error("block count out of range");

    // An empty-pool result must come with no free blocks reported.
    a_empty_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status == fbpa_pkg::ST_EMPTY)) |-> (r_free == '0))
        else $error("pool empty reported with free blocks left");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status != fbpa_pkg::ST_OK)) |->
        ((r_granted == '0) && (r_offset == '0)))
        else $error("failed item carries a grant");

    // Input back-pressure only while a result is stuck at the output.
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_out_valid && !i_out_ready))
        else $error("input stalled without an output stall");

endmodule

/* tb/tb_fixed_block_pool_allocator_unit.sv */
// Self-checking testbench for fixed_block_pool_allocator_unit.
// Depends on fbpa_pkg and the unit's RTL. A scoreboard class tracks the used
// map and offsets; tasks drive requests and register writes.
`timescale 1ns / 1ps

module tb_fixed_block_pool_allocator_unit;

    localparam int MODE_W           = fbpa_pkg::MODE_W;
    localparam int IN_INDEX_W       = fbpa_pkg::IN_INDEX_W;
    localparam int STATUS_W         = fbpa_pkg::STATUS_W;
    localparam int GRANT_W          = fbpa_pkg::GRANT_W;
    localparam int OFFSET_W         = fbpa_pkg::OFFSET_W;
    localparam int COUNT_W          = fbpa_pkg::COUNT_W;
    localparam int CFG_INDEX_W      = fbpa_pkg::CFG_INDEX_W;
    localparam int CFG_DATA_W       = fbpa_pkg::CFG_DATA_W;
    localparam int MAX_BLOCKS_DEF   = fbpa_pkg::MAX_BLOCKS_DEF;
    localparam int HEADER_BYTES_DEF = fbpa_pkg::HEADER_BYTES_DEF;
    localparam int ALIGN_MASK_DEF   = fbpa_pkg::ALIGN_MASK_DEF;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 12;
    localparam int DRAIN_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 200000;

    // Register indexes that the block does not decode.
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_B = 2'd3;

    typedef struct {
        fbpa_pkg::t_status    status;
        logic [GRANT_W-1:0]   granted;
        logic [OFFSET_W-1:0]  offset;
        logic [COUNT_W-1:0]   free_cnt;
    } t_pool_result;

    class t_pool_scoreboard;
        bit           used[MAX_BLOCKS_DEF];
        int           used_total;
        int           blocks;
        int           size_bytes;
        int           errors;
        t_pool_result results_due[$];

        function new();
            blocks     = fbpa_pkg::BLOCK_COUNT_RESET;
            size_bytes = fbpa_pkg::PAYLOAD_LEN_RESET;
            errors     = 0;
            clear_pool();
        endfunction

        function void clear_pool();
            foreach (used[i]) used[i] = 1'b0;
            used_total = 0;
        endfunction

        function int pending();
            return results_due.size();
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            int v;
            if (idx == fbpa_pkg::REG_BLOCK_COUNT) begin
                v = int'(data[COUNT_W-1:0]);
                if (v == 0) v = 1;
                if (v > MAX_BLOCKS_DEF) v = MAX_BLOCKS_DEF;
                blocks = v;
                clear_pool();
            end else if (idx == fbpa_pkg::REG_PAYLOAD_LEN) begin
                v = int'(data);
                if (v == 0) v = 1;
                size_bytes = v;
            end
        endfunction

        function void note_request(logic [MODE_W-1:0] mode, logic [IN_INDEX_W-1:0] idx);
            t_pool_result want;
            int           slot;
            int           stride;
            want.status  = fbpa_pkg::ST_OK;
            want.granted = '0;
            want.offset  = '0;
            slot         = -1;
            if (mode == fbpa_pkg::MODE_ALLOC) begin
                // Scanning downward leaves the lowest free block in slot.
                for (int i = blocks - 1; i >= 0; i--)
                    if (!used[i]) slot = i;
                if (slot < 0) begin
                    want.status = fbpa_pkg::ST_EMPTY;
                end else begin
                    used[slot] = 1'b1;
                    used_total++;
                    stride = (size_bytes + HEADER_BYTES_DEF + ALIGN_MASK_DEF) &
                             ~ALIGN_MASK_DEF;
                    want.granted = GRANT_W'(slot);
                    want.offset  = OFFSET_W'(slot * stride + HEADER_BYTES_DEF);
                end
            end else if (int'(idx) >= blocks) begin
                want.status = fbpa_pkg::ST_RANGE;
            end else if (!used[idx]) begin
                want.status = fbpa_pkg::ST_NOT_ALLOC;
            end else begin
                used[idx] = 1'b0;
                used_total--;
            end
            want.free_cnt = COUNT_W'(blocks - used_total);
            results_due.push_back(want);
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, field, want, got);
            end
        endfunction

        function void check_result(logic [STATUS_W-1:0] status, logic [GRANT_W-1:0] granted,
                                   logic [OFFSET_W-1:0] offset, logic [COUNT_W-1:0] free_cnt);
            t_pool_result want;
            if (results_due.size() == 0) begin
                errors++;
                $display("%0t: result item with none expected, actual status %0d",
                         $time, status);
                $display("%0t: actual index %0d offset %0d free %0d",
                         $time, granted, offset, free_cnt);
                return;
            end
            want = results_due.pop_front();
            compare_field("status", 32'(want.status), 32'(status));
            compare_field("granted_index", 32'(want.granted), 32'(granted));
            compare_field("payload_offset", 32'(want.offset), 32'(offset));
            compare_field("free_count", 32'(want.free_cnt), 32'(free_cnt));
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic [MODE_W-1:0]       i_mode = fbpa_pkg::MODE_ALLOC;
    logic [IN_INDEX_W-1:0]   i_block_index = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic [STATUS_W-1:0]     o_status;
    logic [GRANT_W-1:0]      o_granted_index;
    logic [OFFSET_W-1:0]     o_payload_offset;
    logic [COUNT_W-1:0]      o_free_count;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_INDEX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;

    t_pool_scoreboard sb;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_req = 0;
    int hold_left = 0;
    int cycle_count = 0;

    fixed_block_pool_allocator_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_mode           (i_mode),
        .i_block_index    (i_block_index),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_granted_index  (o_granted_index),
        .o_payload_offset (o_payload_offset),
        .o_free_count     (o_free_count),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // A hold-off request from the stimulus blocks the receiver for the requested hold length.
    always @(negedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                sb.write_reg(i_cfg_index, i_cfg_data);
            if (i_in_valid && o_in_ready)
                sb.note_request(i_mode, i_block_index);
            if (o_out_valid && i_out_ready)
                sb.check_result(o_status, o_granted_index, o_payload_offset, o_free_count);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic set_pacing(input int idle_pct, input int stall, input int hold_len);
        @(posedge i_clk);
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        hold_req      = hold_len;
        @(negedge i_clk);
    endtask

    // Returns at the falling edge after acceptance with valid still high,
    // so that a following item can go out back to back.
    task automatic send_request(input logic [MODE_W-1:0] mode,
                                input logic [IN_INDEX_W-1:0] idx);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_mode        <= mode;
        i_block_index <= idx;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] count_data,
                             input logic [CFG_DATA_W-1:0] size_data,
                             input int items, input int alloc_pct,
                             input int idle_pct, input int stall, input int hold_len);
        int                    held[$];
        logic [IN_INDEX_W-1:0] idx;
        drain_results();
        write_register(fbpa_pkg::REG_BLOCK_COUNT, count_data);
        write_register(fbpa_pkg::REG_PAYLOAD_LEN, size_data);
        set_pacing(idle_pct, stall, 0);
        for (int n = 0; n < items; n++) begin
            if (hold_len > 0 && n == items / 4) begin
                i_in_valid <= 1'b0;
                set_pacing(idle_pct, stall, hold_len);
            end
            if ($urandom_range(99) < alloc_pct) begin
                send_request(fbpa_pkg::MODE_ALLOC, IN_INDEX_W'($urandom_range(63)));
            end else begin
                // Mostly free a block that is really held; otherwise any index.
                held.delete();
                for (int i = 0; i < MAX_BLOCKS_DEF; i++)
                    if (sb.used[i]) held.push_back(i);
                if (held.size() == 0 || $urandom_range(99) < 25)
                    idx = IN_INDEX_W'($urandom_range(63));
                else
                    idx = IN_INDEX_W'(held[$urandom_range(held.size() - 1)]);
                send_request(fbpa_pkg::MODE_FREE, idx);
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        set_pacing(0, 0, 0);

        // Reset state: all 64 blocks free with 64-byte payloads.
        send_request(fbpa_pkg::MODE_ALLOC, '0);
        send_request(fbpa_pkg::MODE_FREE, 6'd0);
        send_request(fbpa_pkg::MODE_FREE, 6'd63);
        drain_results();

        // Two blocks at the largest stride, then empty pool and bad frees.
        write_register(fbpa_pkg::REG_BLOCK_COUNT, 16'd2);
        write_register(fbpa_pkg::REG_PAYLOAD_LEN, 16'hFFFF);
        repeat (3) send_request(fbpa_pkg::MODE_ALLOC, 6'd63);
        send_request(fbpa_pkg::MODE_FREE, 6'd1);
        send_request(fbpa_pkg::MODE_FREE, 6'd1);
        send_request(fbpa_pkg::MODE_FREE, 6'd2);
        send_request(fbpa_pkg::MODE_FREE, 6'd63);
        send_request(fbpa_pkg::MODE_FREE, 6'd0);
        drain_results();

        // Zero count and zero size are both taken as one; unknown registers do nothing.
        write_register(fbpa_pkg::REG_BLOCK_COUNT, 16'd0);
        write_register(fbpa_pkg::REG_PAYLOAD_LEN, 16'd0);
        write_register(REG_UNUSED_A, CFG_DATA_W'($urandom));
        write_register(REG_UNUSED_B, CFG_DATA_W'($urandom));
        repeat (2) send_request(fbpa_pkg::MODE_ALLOC, '0);
        send_request(fbpa_pkg::MODE_FREE, 6'd1);
        send_request(fbpa_pkg::MODE_FREE, 6'd0);
        drain_results();

        // The low seven bits give 72, which clamps to the largest pool.
        write_register(fbpa_pkg::REG_BLOCK_COUNT, 16'hFFC8);
        send_request(fbpa_pkg::MODE_ALLOC, 6'd42);
        send_request(fbpa_pkg::MODE_FREE, 6'd32);

        run_phase(16'd64, 16'hFFFF, 90, 95, 0, 0, 0);
        run_phase(16'd1, 16'd1, 40, 50, 58, 0, 0);
        run_phase(16'd7, 16'd100, 50, 60, 0, 58, 90);
        run_phase(16'h00FF, 16'd13, 60, 55, 32, 32, 0);
        run_phase(16'd3, 16'd40000, 40, 55, 0, 0, 0);
        run_phase(16'd33, 16'd8, 60, 60, 58, 0, 0);
        run_phase(16'd16, 16'hFFFF, 60, 55, 0, 58, 0);
        drain_results();

        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
